/* sv/dmm_pkg.sv */
// shared types and constants for the deque with min/max report
// no dependencies; imported by every other file of the block

package dmm_pkg;

    localparam int VALUE_W  = 17;
    localparam int SPREAD_W = 18;

    localparam logic [VALUE_W-1:0] EMPTY_MIN = VALUE_W'(100000);

    // command codes
    localparam logic [1:0] ACT_PUSH_FRONT = 2'd0;
    localparam logic [1:0] ACT_PUSH_BACK  = 2'd1;
    localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
    localparam logic [1:0] ACT_POP_BACK   = 2'd3;

    // what a cell loads into its data register
    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_LOAD,
        SEL_LEFT,
        SEL_RIGHT
    } cell_sel_t;

    // running extremes handed from cell to cell
    typedef struct packed {
        logic               tok;
        logic [VALUE_W-1:0] hi;
        logic [VALUE_W-1:0] lo;
    } scan_t;

endpackage

/* sv/dmm_ifs.sv */
// handshake interfaces for the command and result channels
// depends on dmm_pkg

interface dmm_cmd_if import dmm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [VALUE_W-1:0] value;

    modport source (output valid, action, value, input ready);
    modport sink   (input valid, action, value, output ready);
endinterface

interface dmm_res_if import dmm_pkg::*; #(parameter int CNT_W = 5) ();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  largest;
    logic [VALUE_W-1:0]  smallest;
    logic [SPREAD_W-1:0] spread;
    logic [CNT_W-1:0]    occupancy;
    logic                dropped;

    modport source (output valid, largest, smallest, spread, occupancy, dropped,
                    input ready);
    modport sink   (input valid, largest, smallest, spread, occupancy, dropped,
                    output ready);
endinterface

/* sv/dmm_cell.sv */
// one storage cell of the deque: holds one entry and folds it into the scan
// depends on dmm_pkg

module dmm_cell import dmm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_sel_t          sel,
    input  logic [VALUE_W-1:0] load_value,
    input  logic [VALUE_W-1:0] left_value,
    input  logic [VALUE_W-1:0] right_value,
    input  logic               occupied,
    input  scan_t              scan_in,
    output logic [VALUE_W-1:0] value,
    output scan_t              scan_out
);

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic               tok_reg;
    logic [VALUE_W-1:0] hi_reg;
    logic [VALUE_W-1:0] lo_reg;
    logic [VALUE_W-1:0] hi_next;
    logic [VALUE_W-1:0] lo_next;

    always_comb
    begin
        case (sel)
            SEL_HOLD:  data_next = data_reg;
            SEL_LOAD:  data_next = load_value;
            SEL_LEFT:  data_next = left_value;
            SEL_RIGHT: data_next = right_value;
            default:   data_next = data_reg;
        endcase
    end

    // fold this entry in only when it lies inside the occupied span
    always_comb
    begin
        hi_next = scan_in.hi;
        lo_next = scan_in.lo;
        if (occupied && (data_reg > scan_in.hi))
        begin
            hi_next = data_reg;
        end
        if (occupied && (data_reg < scan_in.lo))
        begin
            lo_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (scan_in.tok)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= scan_in.tok;
        end
    end

    assign value        = data_reg;
    assign scan_out.tok = tok_reg;
    assign scan_out.hi  = hi_reg;
    assign scan_out.lo  = lo_reg;

endmodule

/* sv/deque_with_min_max.sv */
// top level of the bounded deque with largest/smallest/spread report
// depends on dmm_pkg, dmm_ifs and dmm_cell
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+------------------------------------------------
//  cmd     | in  | valid/ready | action[1:0], value[16:0]
//  res     | out | valid/ready | largest, smallest, spread, occupancy, dropped
//
// one command at a time: after accept the result passes the launch flag, DEPTH cells
// of scan, the done flag and the output register before it is offered on res
// the next command is taken as soon as the result sits in the output register
// a stalled result holds the output register; a finished scan waits behind it
// rst_n clears the control flags, count and scan tokens; entry data is not reset

module deque_with_min_max import dmm_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    dmm_cmd_if.sink     cmd,
    dmm_res_if.source   res
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // entries live in cell 0 (front) .. cell count-1 (back); pushes at the
    // front and pops at the front shift the whole row by one cell
    logic [VALUE_W-1:0] cell_value [DEPTH];
    cell_sel_t          cell_sel   [DEPTH];
    scan_t              scan_link  [DEPTH+1];

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               busy_reg;
    logic               launch_reg;
    logic               done_reg;
    logic               dropped_reg;
    logic               dropped_next;

    logic               res_valid_reg;
    logic [VALUE_W-1:0] largest_reg;
    logic [VALUE_W-1:0] smallest_reg;
    logic [SPREAD_W-1:0] spread_reg;
    logic [CNT_W-1:0]   occupancy_reg;
    logic               res_dropped_reg;

    logic accept;
    logic full;
    logic empty;
    logic res_load;

    assign cmd.ready = !busy_reg;
    assign accept    = cmd.valid && cmd.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign res_load  = done_reg && (!res_valid_reg || res.ready);

    // count and drop flag for the accepted command
    always_comb
    begin
        count_next   = count_reg;
        dropped_next = 1'b0;
        case (cmd.action)
            ACT_PUSH_FRONT,
            ACT_PUSH_BACK:
            begin
                if (full)
                begin
                    dropped_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_POP_FRONT,
            ACT_POP_BACK:
            begin
                if (!empty)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // scan enters cell 0 with the empty-queue extremes
    assign scan_link[0].tok = launch_reg;
    assign scan_link[0].hi  = '0;
    assign scan_link[0].lo  = EMPTY_MIN;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_W-1:0] left_v;
        logic [VALUE_W-1:0] right_v;
        logic               occ;

        if (i == 0)
        begin : g_first
            assign left_v = '0;
        end
        else
        begin : g_inner_l
            assign left_v = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_v = '0;
        end
        else
        begin : g_inner_r
            assign right_v = cell_value[i+1];
        end

        assign occ = (CNT_W'(i) < count_reg);

        // per-cell move for this command
        always_comb
        begin
            cell_sel[i] = SEL_HOLD;
            if (accept)
            begin
                case (cmd.action)
                    ACT_PUSH_FRONT:
                    begin
                        if (!full)
                        begin
                            cell_sel[i] = (i == 0) ? SEL_LOAD : SEL_LEFT;
                        end
                    end
                    ACT_PUSH_BACK:
                    begin
                        if (!full && (count_reg == CNT_W'(i)))
                        begin
                            cell_sel[i] = SEL_LOAD;
                        end
                    end
                    ACT_POP_FRONT:
                    begin
                        if (!empty)
                        begin
                            cell_sel[i] = SEL_RIGHT;
                        end
                    end
                    default:
                    begin
                        cell_sel[i] = SEL_HOLD;
                    end
                endcase
            end
        end

        dmm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .sel         (cell_sel[i]),
            .load_value  (cmd.value),
            .left_value  (left_v),
            .right_value (right_v),
            .occupied    (occ),
            .scan_in     (scan_link[i]),
            .value       (cell_value[i]),
            .scan_out    (scan_link[i+1])
        );
    end

    // control: one command in flight, scan launch and completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            launch_reg    <= 1'b0;
            done_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            launch_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
                busy_reg  <= 1'b1;
            end
            else if (res_load)
            begin
                busy_reg <= 1'b0;
            end

            // last cell token marks the end of the scan; its extremes then hold
            if (scan_link[DEPTH].tok)
            begin
                done_reg <= 1'b1;
            end
            else if (res_load)
            begin
                done_reg <= 1'b0;
            end

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dropped_reg <= dropped_next;
        end
        if (res_load)
        begin
            largest_reg     <= scan_link[DEPTH].hi;
            smallest_reg    <= scan_link[DEPTH].lo;
            spread_reg      <= {1'b0, scan_link[DEPTH].hi} - {1'b0, scan_link[DEPTH].lo};
            occupancy_reg   <= count_reg;
            res_dropped_reg <= dropped_reg;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.largest   = largest_reg;
    assign res.smallest  = smallest_reg;
    assign res.spread    = spread_reg;
    assign res.occupancy = occupancy_reg;
    assign res.dropped   = res_dropped_reg;

endmodule

/* sv/dmm_check.sv */
// port-level checker for deque_with_min_max, attached by bind
// depends on dmm_pkg

module dmm_check import dmm_pkg::*;
#(
    parameter int CNT_W = 5
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [VALUE_W-1:0]  largest,
    input logic [VALUE_W-1:0]  smallest,
    input logic [SPREAD_W-1:0] spread,
    input logic [CNT_W-1:0]    occupancy
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // one command at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command taken while another is in flight");

    // spread is the difference of the reported extremes
    a_spread: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> spread == ({1'b0, largest} - {1'b0, smallest}))
        else $error("spread does not match largest minus smallest");

    // empty queue reports the start values
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (occupancy == '0) |-> (largest == '0) && (smallest == EMPTY_MIN))
        else $error("empty queue reports wrong extremes");

    // smallest never exceeds its start value
    a_small_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> smallest <= EMPTY_MIN)
        else $error("smallest above start value");

endmodule

bind deque_with_min_max dmm_check #(.CNT_W($clog2(DEPTH + 1))) u_dmm_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .largest   (res.largest),
    .smallest  (res.smallest),
    .spread    (res.spread),
    .occupancy (res.occupancy)
);

/* tb/dmm_report_checker.sv */
`timescale 1ns / 100ps
// checker for the deque with min/max report: watches both channels, predicts
// every report from its own copy of the deque and compares it field by field
// depends on dmm_pkg and dmm_ifs

module dmm_report_checker import dmm_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5
)
(
    input  logic clk,
    input  logic rst_n,
    dmm_cmd_if   cmd,
    dmm_res_if   res,
    output int   fail_count,
    output int   pending,
    output int   report_count,
    output int   refused_pushes,
    output int   empty_pops,
    output int   full_reports
);

    localparam int IDX_W = $clog2(DEPTH);

    typedef struct packed {
        logic [VALUE_W-1:0]  largest;
        logic [VALUE_W-1:0]  smallest;
        logic [SPREAD_W-1:0] spread;
        logic [CNT_W-1:0]    occupancy;
        logic                dropped;
    } report_t;

    // shadow deque
    logic [VALUE_W-1:0] slots [DEPTH];
    int                 front;
    int                 count;

    report_t expected_reports [$];
    report_t seen;
    report_t want;

    // apply one operation to the shadow deque and rescan the occupied slots
    function automatic report_t deque_after_op(input logic [1:0] action,
                                               input logic [VALUE_W-1:0] value);
        report_t            r;
        logic [VALUE_W-1:0] hi;
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] v;
        hi        = '0;
        lo        = EMPTY_MIN;
        r.dropped = 1'b0;
        case (action)
            ACT_PUSH_FRONT:
            begin
                if (count >= DEPTH)
                    r.dropped = 1'b1;
                else
                begin
                    front                 = (front + DEPTH - 1) % DEPTH;
                    slots[IDX_W'(front)] = value;
                    count++;
                end
            end
            ACT_PUSH_BACK:
            begin
                if (count >= DEPTH)
                    r.dropped = 1'b1;
                else
                begin
                    slots[IDX_W'((front + count) % DEPTH)] = value;
                    count++;
                end
            end
            ACT_POP_FRONT:
            begin
                if (count != 0)
                begin
                    front = (front + 1) % DEPTH;
                    count--;
                end
            end
            default:
            begin
                if (count != 0)
                    count--;
            end
        endcase
        for (int k = 0; k < count; k++)
        begin
            v = slots[IDX_W'((front + k) % DEPTH)];
            if (v > hi)
                hi = v;
            if (v < lo)
                lo = v;
        end
        r.largest   = hi;
        r.smallest  = lo;
        r.spread    = SPREAD_W'(hi) - SPREAD_W'(lo);
        r.occupancy = CNT_W'(count);
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front = 0;
            count = 0;
            expected_reports.delete();
            pending = 0;
        end
        else
        begin
            // result first: a new command can be taken on the edge that frees the output
            if (res.valid && res.ready)
            begin
                report_count++;
                if (expected_reports.size() == 0)
                begin
                    $error("report with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    seen = '{res.largest, res.smallest, res.spread, res.occupancy,
                             res.dropped};
                    check_field("largest", int'(want.largest), int'(seen.largest));
                    check_field("smallest", int'(want.smallest), int'(seen.smallest));
                    check_field("spread", int'($signed(want.spread)),
                                int'($signed(seen.spread)));
                    check_field("occupancy", int'(want.occupancy), int'(seen.occupancy));
                    check_field("dropped", int'(want.dropped), int'(seen.dropped));
                    if (int'(want.occupancy) == DEPTH)
                        full_reports++;
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                if (count == 0 && (cmd.action == ACT_POP_FRONT || cmd.action == ACT_POP_BACK))
                    empty_pops++;
                want = deque_after_op(cmd.action, cmd.value);
                if (want.dropped)
                    refused_pushes++;
                expected_reports.push_back(want);
            end
            pending = expected_reports.size();
        end
    end

endmodule

/* tb/deque_with_min_max_test.sv */
`timescale 1ns / 100ps
// top of the deque with min/max regression: clock, reset, command stimulus,
// result back-pressure and the verdict; depends on dmm_pkg, dmm_ifs, the block
// and dmm_report_checker

module deque_with_min_max_test import dmm_pkg::*;;

    localparam int DEPTH        = 16;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int RANDOM_ITEMS = 1700;
    localparam int MAX_GAP      = 12;
    // long result stall, well past the one-command-at-a-time pipeline
    localparam int LONG_HOLD    = 300;
    // settle time at the end of the run, after the last report is back
    localparam int SETTLE       = 2 * DEPTH + 8;

    // random walk flavors for the command mix
    typedef enum logic [1:0] {
        WALK_FILL,
        WALK_DRAIN,
        WALK_MIXED
    } walk_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dmm_cmd_if cmd_ch ();
    dmm_res_if #(.CNT_W(CNT_W)) res_ch ();

    int fail_count;
    int pending;
    int report_count;
    int refused_pushes;
    int empty_pops;
    int full_reports;

    // sender side burst control: while nonzero, items go back to back
    int send_quiet;

    deque_with_min_max #(.DEPTH(DEPTH)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    dmm_report_checker #(.DEPTH(DEPTH), .CNT_W(CNT_W)) report_chk
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd_ch),
        .res            (res_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .report_count   (report_count),
        .refused_pushes (refused_pushes),
        .empty_pops     (empty_pops),
        .full_reports   (full_reports)
    );

    // 8 ns period
    always #4 clk = ~clk;

    // offer one command item, after a random gap, and hold it until accepted
    // returns right after the accepting edge with valid still high
    task automatic offer_item(input logic [1:0] action, input logic [VALUE_W-1:0] value);
        int gap;
        if (send_quiet > 0)
        begin
            gap = 0;
            send_quiet--;
        end
        else
        begin
            gap = $urandom_range(0, MAX_GAP);
            // now and then a back-to-back stretch
            if ($urandom_range(0, 19) == 0)
                send_quiet = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.action <= action;
        cmd_ch.value  <= value;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    // park the command side until every report has come back
    task automatic drain_reports();
        cmd_ch.valid <= 1'b0;
        // pending is updated on the same edge; let that edge pass before reading it
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // values weighted toward the edges: zero, the empty-min constant, values around it,
    // the 17-bit maximum, full-width noise and uniform values from 0 to 100000
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = EMPTY_MIN;
            2:       v = '1;
            3:       v = VALUE_W'($urandom_range(99990, 100010));
            4, 5:    v = VALUE_W'($urandom);
            default: v = VALUE_W'($urandom_range(0, 100000));
        endcase
        return v;
    endfunction

    // directed fill values: extremes, alternating bit patterns, around 100000
    logic [VALUE_W-1:0] fill_values [DEPTH] = '{
        17'd0, 17'h1FFFF, 17'd100000, 17'd1, 17'd99999, 17'h10000, 17'h0AAAA,
        17'h15555, 17'd2, 17'd100000, 17'd50000, 17'd3, 17'd100001, 17'd7,
        17'd12345, 17'd99998
    };

    // command side: reset, directed part, random walk, end of run
    initial
    begin : command_source
        walk_t      walk;
        int         walk_left;
        int         push_odds;
        logic [1:0] action;

        walk_left     = 0;
        send_quiet    = 0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.action <= ACT_PUSH_FRONT;
        cmd_ch.value  <= '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pops on an empty deque change nothing
        offer_item(ACT_POP_FRONT, 17'h1FFFF);
        offer_item(ACT_POP_BACK, '0);

        // fill to the brim from both ends, wrapping the front index
        for (int k = 0; k < DEPTH; k++)
            offer_item(k[0] ? ACT_PUSH_BACK : ACT_PUSH_FRONT, fill_values[IDX_W'(k)]);

        // pushes on a full deque are refused at either end
        offer_item(ACT_PUSH_FRONT, 17'd4);
        offer_item(ACT_PUSH_BACK, 17'd5);

        // pops at both ends
        offer_item(ACT_POP_FRONT, '0);
        offer_item(ACT_POP_BACK, '0);
        offer_item(ACT_POP_FRONT, '0);

        // random walk: fill, drain and mixed stretches push the occupancy
        // through empty and full over and over
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (walk_left == 0)
            begin
                walk      = walk_t'($urandom_range(0, 2));
                walk_left = $urandom_range(20, 60);
            end
            walk_left--;
            case (walk)
                WALK_FILL:  push_odds = 75;
                WALK_DRAIN: push_odds = 25;
                default:    push_odds = 50;
            endcase
            if ($urandom_range(0, 99) < push_odds)
                action = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
            else
                action = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
            offer_item(action, pick_value());

            // halfway through, let the block run dry before going on
            if (i == RANDOM_ITEMS / 2)
                drain_reports();
        end

        drain_reports();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d reports: %0d refused pushes, %0d pops on an empty deque,",
                 report_count, refused_pushes, empty_pops);
        $display("%0d reports at full depth, with random and long stalls on both sides",
                 full_reports);
        if (fail_count == 0)
            $display("deque_with_min_max regression: pass");
        else
            $display("deque_with_min_max regression: fail");
        $finish;
    end

    // result side: random ready gaps, quiet stretches, and two long holds
    // counted here while the command side keeps offering items
    initial
    begin : report_sink
        int hold;
        int taken;
        int quiet;

        taken = 0;
        quiet = 0;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (taken == 200 || taken == 1100)
                hold = LONG_HOLD;
            else if (quiet > 0)
            begin
                hold = 0;
                quiet--;
            end
            else
            begin
                hold = $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 19) == 0)
                    quiet = $urandom_range(10, 40);
            end
            if (hold > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
            taken++;
        end
    end

    // watchdog, several times the slowest legal run
    initial
    begin : watchdog
        #5_000_000;
        $display("deque_with_min_max regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
sv/dmm_pkg.sv
sv/dmm_ifs.sv
sv/dmm_cell.sv
sv/deque_with_min_max.sv
sv/dmm_check.sv
tb/dmm_report_checker.sv
tb/deque_with_min_max_test.sv
